### rtl/lzss_pkg.sv
// Shared types and constants of the LZSS bitstream decoder.
// No dependencies; every other file of the block but lzss_ram imports this package.
package lzss_pkg;

  localparam int BYTE_BITS = 8;
  localparam int MATCH_MIN = 2;
  localparam int LW_W      = 3;
  localparam int OW_W      = 4;
  localparam int FBL_W     = 4;
  localparam int BCNT_W    = 4;
  localparam int PROD_W    = 16;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [PROD_W-1:0] OUT_LEN_RESET = 16'hFFFF;

  localparam logic [1:0] HDR_LEN_IDX   = 2'd0;
  localparam logic [1:0] HDR_SHORT_IDX = 2'd1;
  localparam logic [1:0] HDR_LONG_IDX  = 2'd2;
  localparam logic [1:0] HDR_DONE      = 2'd3;

  typedef enum logic [1:0] {
    STAT_DATA    = 2'd0,
    STAT_DONE    = 2'd1,
    STAT_HDR_ERR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_FLAG2,
    PH_SHORT,
    PH_LONG,
    PH_LEN,
    PH_LIT
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_BIT,
    S_SETTLE,
    S_RD,
    S_WR,
    S_CHK,
    S_FLUSH
  } dec_state_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    status_t              status;
  } res_t;

  typedef struct packed {
    logic push;
    logic flush;
  } res_ctl_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    status_t              status;
    logic                 last;
  } out_rec_t;

endpackage

### rtl/lzss_if.sv
// Valid/ready channel interfaces for compressed input and decoded results.
// Depends on lzss_pkg for the payload widths.
interface lzss_in_if;
  import lzss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] in_byte;
  logic                 first;
  modport source (output valid, output in_byte, output first, input ready);
  modport sink (input valid, input in_byte, input first, output ready);
endinterface

interface lzss_out_if;
  import lzss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic [1:0]           status;
  logic                 last;
  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

### rtl/lzss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/lzss_outq.sv
// Result staging: a hold stage that decides the last flag and an output register.
// Depends on lzss_pkg and lzss_out_if.
module lzss_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  lzss_pkg::res_ctl_t ctl,
  input  lzss_pkg::res_t     res,
  output logic              ok,
  lzss_out_if.source        out_ch
);
  import lzss_pkg::*;

  logic     hold_v_r, hold_v_nxt;
  res_t     hold_r, hold_nxt;
  logic     out_v_r, out_v_nxt;
  out_rec_t out_d_r, out_d_nxt;
  logic     out_free;

  assign out_free = !out_v_r || out_ch.ready;
  assign ok       = !hold_v_r || out_free;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    out_d_nxt  = out_d_r;
    if (ctl.push && ok) begin
      if (hold_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = '{out_byte: hold_r.out_byte, status: hold_r.status, last: 1'b0};
      end
      hold_nxt   = res;
      hold_v_nxt = 1'b1;
    end else if (ctl.flush && hold_v_r && out_free) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = '{out_byte: hold_r.out_byte, status: hold_r.status, last: 1'b1};
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    hold_r  <= hold_nxt;
    out_d_r <= out_d_nxt;
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.out_byte = out_d_r.out_byte;
  assign out_ch.status   = out_d_r.status;
  assign out_ch.last     = out_d_r.last;

endmodule

### rtl/lzss_dec.sv
// Bit-serial token parser and match copy sequencer with the history RAM.
// Depends on lzss_pkg, lzss_in_if and lzss_ram.
module lzss_dec #(
  parameter int HISTORY_DEPTH    = 8192,
  parameter int LEN_FIELD_MAX    = 4,
  parameter int OFFSET_FIELD_MAX = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lzss_in_if.sink                     in_ch,
  input  logic [lzss_pkg::PROD_W-1:0] out_len,
  output lzss_pkg::res_ctl_t          ctl,
  output lzss_pkg::res_t              res,
  input  logic                        ok
);
  import lzss_pkg::*;

  localparam int FW  = (OFFSET_FIELD_MAX > BYTE_BITS) ? OFFSET_FIELD_MAX : BYTE_BITS;
  localparam int DW  = OFFSET_FIELD_MAX + 2;
  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = ((DW > PROD_W + 1) ? DW : PROD_W + 1) + 1;
  localparam int CNW = LEN_FIELD_MAX + 1;
  localparam int PW1 = PROD_W + 1;

  dec_state_t           state_r, state_nxt;
  logic [BYTE_BITS-1:0] sh_r, sh_nxt;
  logic [BCNT_W-1:0]    bleft_r, bleft_nxt;
  logic [1:0]           hidx_r, hidx_nxt;
  logic [LW_W-1:0]      lw_r, lw_nxt;
  logic [OW_W-1:0]      sw_r, sw_nxt;
  logic [OW_W-1:0]      lgw_r, lgw_nxt;
  phase_t               phase_r, phase_nxt;
  logic [FBL_W-1:0]     fbl_r, fbl_nxt;
  logic [FW-1:0]        fv_r, fv_nxt;
  logic [DW-1:0]        dist_r, dist_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic                 fin_r, fin_nxt;
  logic [AW-1:0]        wptr_r, wptr_nxt;
  logic [CNW-1:0]       cnt_r, cnt_nxt;
  logic                 rdok_r, rdok_nxt;

  logic                 bit_in;
  logic                 at_end;
  logic                 hdr_err;
  logic                 fin_eff;
  logic [1:0]           hidx_eff;
  logic [PW1-1:0]       need;
  logic [CW-1:0]        diff;
  logic                 dist_ok;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        wptr_inc;
  logic                 we;
  logic                 re;
  logic [BYTE_BITS-1:0] ram_q;
  dec_state_t           cont;

  assign bit_in   = sh_r[BYTE_BITS-1];
  assign at_end   = prod_r >= out_len;
  assign fin_eff  = in_ch.first ? 1'b0 : fin_r;
  assign hidx_eff = in_ch.first ? HDR_LEN_IDX : hidx_r;
  assign need     = {1'b0, prod_r} + PW1'(fv_r) + PW1'(MATCH_MIN);
  assign dist_ok  = (CW'(dist_r) <= CW'(prod_r)) && (CW'(dist_r) <= CW'(HISTORY_DEPTH));
  assign wptr_inc = (wptr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign cont     = (bleft_r != '0) ? S_BIT : S_FLUSH;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    diff = CW'(wptr_r) - CW'(dist_r);
    if (diff[CW-1]) begin
      diff = diff + CW'(HISTORY_DEPTH);
    end
    raddr = diff[AW-1:0];
  end

  always_comb begin
    hdr_err = (hidx_r == HDR_LEN_IDX) ? (sh_r > BYTE_BITS'(LEN_FIELD_MAX))
                                      : (sh_r > BYTE_BITS'(OFFSET_FIELD_MAX));
  end

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    bleft_nxt = bleft_r;
    hidx_nxt  = hidx_r;
    lw_nxt    = lw_r;
    sw_nxt    = sw_r;
    lgw_nxt   = lgw_r;
    phase_nxt = phase_r;
    fbl_nxt   = fbl_r;
    fv_nxt    = fv_r;
    dist_nxt  = dist_r;
    prod_nxt  = prod_r;
    fin_nxt   = fin_r;
    wptr_nxt  = wptr_r;
    cnt_nxt   = cnt_r;
    rdok_nxt  = rdok_r;
    ctl       = '0;
    res       = '{out_byte: '0, status: STAT_DATA};
    we        = 1'b0;
    re        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sh_nxt    = in_ch.in_byte;
          bleft_nxt = BCNT_W'(BYTE_BITS);
          if (in_ch.first) begin
            hidx_nxt  = HDR_LEN_IDX;
            phase_nxt = PH_FLAG;
            fbl_nxt   = '0;
            fv_nxt    = '0;
            dist_nxt  = '0;
            prod_nxt  = '0;
            wptr_nxt  = '0;
            fin_nxt   = 1'b0;
          end
          if (fin_eff) begin
            state_nxt = S_IDLE;
          end else if (hidx_eff != HDR_DONE) begin
            state_nxt = S_HDR;
          end else begin
            state_nxt = S_BIT;
          end
        end
      end
      S_HDR: begin
        if (hdr_err) begin
          if (ok) begin
            ctl.push   = 1'b1;
            res.status = STAT_HDR_ERR;
            fin_nxt    = 1'b1;
            hidx_nxt   = hidx_r + 1'b1;
            state_nxt  = S_FLUSH;
          end
        end else if (hidx_r == HDR_LONG_IDX && at_end) begin
          if (ok) begin
            lgw_nxt    = sh_r[OW_W-1:0];
            ctl.push   = 1'b1;
            res.status = STAT_DONE;
            fin_nxt    = 1'b1;
            hidx_nxt   = hidx_r + 1'b1;
            state_nxt  = S_FLUSH;
          end
        end else begin
          case (hidx_r)
            HDR_LEN_IDX:   lw_nxt  = sh_r[LW_W-1:0];
            HDR_SHORT_IDX: sw_nxt  = sh_r[OW_W-1:0];
            default:       lgw_nxt = sh_r[OW_W-1:0];
          endcase
          hidx_nxt  = hidx_r + 1'b1;
          state_nxt = S_FLUSH;
        end
      end
      S_BIT: begin
        if (phase_r == PH_FLAG && at_end) begin
          if (ok) begin
            ctl.push   = 1'b1;
            res.status = STAT_DONE;
            fin_nxt    = 1'b1;
            state_nxt  = S_FLUSH;
          end
        end else begin
          case (phase_r)
            PH_FLAG: begin
              if (bit_in) begin
                phase_nxt = PH_FLAG2;
              end else begin
                phase_nxt = PH_SHORT;
                fbl_nxt   = FBL_W'(sw_r);
                fv_nxt    = '0;
              end
            end
            PH_FLAG2: begin
              if (bit_in) begin
                phase_nxt = PH_LIT;
                fbl_nxt   = FBL_W'(BYTE_BITS);
              end else begin
                phase_nxt = PH_LONG;
                fbl_nxt   = FBL_W'(lgw_r);
              end
              fv_nxt = '0;
            end
            default: begin
              if (fbl_r != '0) begin
                fv_nxt  = {fv_r[FW-2:0], bit_in};
                fbl_nxt = fbl_r - 1'b1;
              end else begin
                phase_nxt = PH_FLAG;
              end
            end
          endcase
          sh_nxt    = {sh_r[BYTE_BITS-2:0], 1'b0};
          bleft_nxt = bleft_r - 1'b1;
          if (phase_nxt != PH_FLAG && phase_nxt != PH_FLAG2 && fbl_nxt == '0) begin
            state_nxt = S_SETTLE;
          end else if (bleft_nxt == '0) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_BIT;
          end
        end
      end
      S_SETTLE: begin
        case (phase_r)
          PH_SHORT, PH_LONG: begin
            if (phase_r == PH_SHORT) begin
              dist_nxt = DW'(fv_r) + DW'(MATCH_MIN);
            end else begin
              dist_nxt = DW'(fv_r) + (DW'(1) << sw_r) + DW'(MATCH_MIN);
            end
            phase_nxt = PH_LEN;
            fbl_nxt   = FBL_W'(lw_r);
            fv_nxt    = '0;
            state_nxt = (lw_r == '0) ? S_SETTLE : cont;
          end
          PH_LEN: begin
            if (need > {1'b0, out_len}) begin
              if (ok) begin
                ctl.push   = 1'b1;
                res.status = STAT_DONE;
                fin_nxt    = 1'b1;
                phase_nxt  = PH_FLAG;
                state_nxt  = S_FLUSH;
              end
            end else begin
              cnt_nxt   = CNW'(fv_r) + CNW'(MATCH_MIN);
              phase_nxt = PH_FLAG;
              state_nxt = S_RD;
            end
          end
          PH_LIT: begin
            res.out_byte = fv_r[BYTE_BITS-1:0];
            if (ok) begin
              ctl.push  = 1'b1;
              we        = 1'b1;
              prod_nxt  = prod_r + 1'b1;
              wptr_nxt  = wptr_inc;
              phase_nxt = PH_FLAG;
              state_nxt = S_CHK;
            end
          end
          default: begin
            phase_nxt = PH_FLAG;
            state_nxt = cont;
          end
        endcase
      end
      S_RD: begin
        re        = 1'b1;
        rdok_nxt  = dist_ok;
        state_nxt = S_WR;
      end
      S_WR: begin
        res.out_byte = rdok_r ? ram_q : '0;
        if (ok) begin
          ctl.push  = 1'b1;
          we        = 1'b1;
          prod_nxt  = prod_r + 1'b1;
          wptr_nxt  = wptr_inc;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = (cnt_r == CNW'(1)) ? S_CHK : S_RD;
        end
      end
      S_CHK: begin
        if (at_end) begin
          if (ok) begin
            ctl.push   = 1'b1;
            res.status = STAT_DONE;
            fin_nxt    = 1'b1;
            state_nxt  = S_FLUSH;
          end
        end else begin
          state_nxt = cont;
        end
      end
      S_FLUSH: begin
        ctl.flush = 1'b1;
        if (ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hidx_r  <= HDR_LEN_IDX;
      lw_r    <= '0;
      sw_r    <= '0;
      lgw_r   <= '0;
      phase_r <= PH_FLAG;
      fbl_r   <= '0;
      fv_r    <= '0;
      dist_r  <= '0;
      prod_r  <= '0;
      fin_r   <= 1'b1;
      wptr_r  <= '0;
      cnt_r   <= '0;
      bleft_r <= '0;
      rdok_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hidx_r  <= hidx_nxt;
      lw_r    <= lw_nxt;
      sw_r    <= sw_nxt;
      lgw_r   <= lgw_nxt;
      phase_r <= phase_nxt;
      fbl_r   <= fbl_nxt;
      fv_r    <= fv_nxt;
      dist_r  <= dist_nxt;
      prod_r  <= prod_nxt;
      fin_r   <= fin_nxt;
      wptr_r  <= wptr_nxt;
      cnt_r   <= cnt_nxt;
      bleft_r <= bleft_nxt;
      rdok_r  <= rdok_nxt;
    end
    sh_r <= sh_nxt;
  end

  lzss_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wptr_r),
    .wdata (res.out_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

endmodule

### rtl/lzss_bitstream_decoder.sv
// Top level of the LZSS bitstream decoder: configuration register, parser and result stage.
// Depends on lzss_pkg, lzss_if, lzss_dec and lzss_outq.
//
// The decoder takes one compressed byte per transfer; a byte with first set starts a new
// stream, whose first three bytes are the header. A header byte passes a header check step
// and a flush step. A token byte is shifted through a one-bit-per-cycle parser; each
// completed field then passes a settle step, every byte copied out of the history RAM a
// read step and then a write-and-emit step, and each literal or match an end check; a
// final flush step releases the last result, which marks it with last. A byte that ends
// the stream stops shifting early, and a byte that arrives while no stream is open is
// accepted and dropped. Any result also waits while both the hold stage and the output
// register are occupied. The input is not ready while a byte is being parsed; the finished
// results of a byte are held in an output register, so the next byte may be accepted while
// the last result still waits to be taken. Matches read the history RAM through its single
// registered read port, which sets the copy rate. The length register is written over the
// APB-style port at byte address 0.
module lzss_bitstream_decoder #(
  parameter int HISTORY_DEPTH    = 8192,
  parameter int LEN_FIELD_MAX    = 4,
  parameter int OFFSET_FIELD_MAX = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lzss_in_if.sink                     in_ch,
  lzss_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lzss_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [lzss_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lzss_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import lzss_pkg::*;

  logic [PROD_W-1:0] out_len_r, out_len_nxt;
  logic              sel_len;
  res_ctl_t          ctl;
  res_t              res;
  logic              ok;

  assign sel_len    = !cfg_paddr[CFG_AW-1];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_len ? CFG_DW'(out_len_r) : '0;

  always_comb begin
    out_len_nxt = out_len_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_len) begin
      out_len_nxt = cfg_pwdata[PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r <= OUT_LEN_RESET;
    end else begin
      out_len_r <= out_len_nxt;
    end
  end

  lzss_dec #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .LEN_FIELD_MAX    (LEN_FIELD_MAX),
    .OFFSET_FIELD_MAX (OFFSET_FIELD_MAX)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_len (out_len_r),
    .ctl     (ctl),
    .res     (res),
    .ok      (ok)
  );

  lzss_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .res    (res),
    .ok     (ok),
    .out_ch (out_ch)
  );

endmodule

### test/lzss_stream_checker.sv
// Watches the compressed-byte channel, the result channel and the length register writes of
// the LZSS bitstream decoder, predicts the decoded results and compares them in order.
// Depends on lzss_pkg and the channel interfaces in lzss_if.
module lzss_stream_checker #(
  parameter int HISTORY_DEPTH    = 8192,
  parameter int LEN_FIELD_MAX    = 4,
  parameter int OFFSET_FIELD_MAX = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lzss_in_if                          in_ch,
  lzss_out_if                         out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lzss_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [lzss_pkg::CFG_DW-1:0] cfg_pwdata,
  input  logic                        cfg_pready,
  output int                          errors,
  output int                          pending,
  output int                          checked
);
  import lzss_pkg::*;

  localparam int RESULTS_PER_BYTE_MAX = 35;
  localparam int REG_OUTPUT_LENGTH    = 0;
  localparam logic [CFG_AW-1:0] ADDR_OUTPUT_LENGTH = CFG_AW'(4 * REG_OUTPUT_LENGTH);

  logic [PROD_W-1:0] out_len;
  logic [1:0]        hdr_idx;
  logic [LW_W-1:0]   len_w;
  logic [OW_W-1:0]   short_w;
  logic [OW_W-1:0]   long_w;
  phase_t            phase;
  logic [FBL_W-1:0]  bits_left;
  logic [12:0]       field_val;
  logic [13:0]       distance;
  logic [PROD_W-1:0] produced;
  logic              done;
  logic [7:0]        history [HISTORY_DEPTH];

  out_rec_t byte_results[$];
  out_rec_t due_results[$];
  int       err_n = 0;
  int       chk_n = 0;

  function automatic void emit(input logic [7:0] data, input status_t st);
    out_rec_t rec;
    rec.out_byte = data;
    rec.status   = st;
    rec.last     = 1'b0;
    if (byte_results.size() < RESULTS_PER_BYTE_MAX) byte_results.push_back(rec);
  endfunction

  function automatic void finish_stream(input status_t st);
    if (done) return;
    done = 1'b1;
    emit(8'h00, st);
  endfunction

  function automatic void end_check();
    if (!done && produced >= out_len) finish_stream(STAT_DONE);
  endfunction

  function automatic void store_byte(input logic [7:0] data);
    history[produced % HISTORY_DEPTH] = data;
    produced = produced + 1'b1;
    emit(data, STAT_DATA);
  endfunction

  function automatic void begin_field(input phase_t p, input int unsigned w);
    phase     = p;
    bits_left = FBL_W'(w);
    field_val = '0;
  endfunction

  function automatic void copy_match();
    int unsigned cnt;
    int unsigned rem;
    logic [7:0]  data;
    cnt   = field_val + 2;
    rem   = (produced < out_len) ? out_len - produced : 0;
    phase = PH_FLAG;
    if (cnt > rem) begin
      finish_stream(STAT_DONE);
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      data = 8'h00;
      if (distance <= produced && distance <= HISTORY_DEPTH)
        data = history[(produced - distance) % HISTORY_DEPTH];
      store_byte(data);
    end
    end_check();
  endfunction

  function automatic void settle();
    while (!done && bits_left == 0 && phase != PH_FLAG && phase != PH_FLAG2) begin
      case (phase)
        PH_SHORT: begin
          distance = 14'(field_val + 2);
          begin_field(PH_LEN, len_w);
        end
        PH_LONG: begin
          distance = 14'(field_val + (1 << short_w) + 2);
          begin_field(PH_LEN, len_w);
        end
        PH_LEN: copy_match();
        default: begin
          phase = PH_FLAG;
          store_byte(field_val[7:0]);
          end_check();
        end
      endcase
    end
  endfunction

  function automatic void take_bit(input logic b);
    case (phase)
      PH_FLAG: begin
        end_check();
        if (done) return;
        if (b) phase = PH_FLAG2;
        else begin_field(PH_SHORT, short_w);
      end
      PH_FLAG2: begin
        if (b) begin_field(PH_LIT, 8);
        else begin_field(PH_LONG, long_w);
      end
      default: begin
        if (bits_left > 0) begin
          field_val = {field_val[11:0], b};
          bits_left = bits_left - 1'b1;
        end else begin
          phase = PH_FLAG;
        end
      end
    endcase
    settle();
  endfunction

  function automatic void decode_byte(input logic [7:0] data, input logic first);
    out_rec_t rec;
    byte_results.delete();
    if (first) begin
      hdr_idx   = HDR_LEN_IDX;
      phase     = PH_FLAG;
      bits_left = '0;
      field_val = '0;
      distance  = '0;
      produced  = '0;
      done      = 1'b0;
    end
    if (done) return;
    if (hdr_idx != HDR_DONE) begin
      if (hdr_idx == HDR_LEN_IDX) begin
        if (data > LEN_FIELD_MAX) finish_stream(STAT_HDR_ERR);
        else len_w = data[LW_W-1:0];
      end else if (data > OFFSET_FIELD_MAX) begin
        finish_stream(STAT_HDR_ERR);
      end else if (hdr_idx == HDR_SHORT_IDX) begin
        short_w = data[OW_W-1:0];
      end else begin
        long_w = data[OW_W-1:0];
      end
      hdr_idx = hdr_idx + 1'b1;
      if (hdr_idx == HDR_DONE) end_check();
    end else begin
      for (int k = 0; k < 8 && !done; k++) take_bit(data[7-k]);
    end
    if (byte_results.size() > 0) begin
      rec      = byte_results.pop_back();
      rec.last = 1'b1;
      byte_results.push_back(rec);
    end
    foreach (byte_results[i]) due_results.push_back(byte_results[i]);
  endfunction

  always @(posedge clk) begin
    out_rec_t want;
    if (!rst_n) begin
      out_len   = OUT_LEN_RESET;
      hdr_idx   = HDR_LEN_IDX;
      len_w     = '0;
      short_w   = '0;
      long_w    = '0;
      phase     = PH_FLAG;
      bits_left = '0;
      field_val = '0;
      distance  = '0;
      produced  = '0;
      done      = 1'b1;
      due_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_OUTPUT_LENGTH)
        out_len = cfg_pwdata[PROD_W-1:0];
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte, in_ch.first);
      if (out_ch.valid && out_ch.ready) begin
        chk_n++;
        if (due_results.size() == 0) begin
          err_n++;
          $display("%0t: unexpected result byte %h status %0d last %b, none expected",
                   $time, out_ch.out_byte, out_ch.status, out_ch.last);
        end else begin
          want = due_results.pop_front();
          if (out_ch.out_byte !== want.out_byte || out_ch.status !== want.status ||
              out_ch.last !== want.last) begin
            err_n++;
            $display("%0t: expected byte %h status %0d last %b, got byte %h status %0d last %b",
                     $time, want.out_byte, want.status, want.last,
                     out_ch.out_byte, out_ch.status, out_ch.last);
          end
        end
      end
    end
    errors  <= err_n;
    checked <= chk_n;
    pending <= due_results.size();
  end

endmodule

### test/lzss_bitstream_decoder_test.sv
// Top of the LZSS bitstream decoder testbench: clock, reset, compressed stream stimulus,
// length register writes, receiver stalls and the verdict.
// Depends on lzss_pkg, lzss_if, the decoder RTL and lzss_stream_checker.
module lzss_bitstream_decoder_test;
  import lzss_pkg::*;

  localparam int HIST_DEPTH        = 8192;
  localparam int LEN_MAX           = 4;
  localparam int OFF_MAX           = 12;
  localparam int RANDOM_ITEMS      = 430;
  localparam int SETTLE_CYCLES     = 100;
  localparam int HOLD_CYCLES       = 400;
  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int REG_OUTPUT_LENGTH = 0;
  localparam logic [CFG_AW-1:0] ADDR_OUTPUT_LENGTH = CFG_AW'(4 * REG_OUTPUT_LENGTH);

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int          chk_errors;
  int          chk_pending;
  int          chk_results;
  int          cycles = 0;
  int          tx_idle_pct = 17;
  int          rx_idle_pct = 82;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          items_sent = 0;
  int          streams = 0;
  int          cfg_writes = 0;
  int          base;
  int unsigned cur_len = 65535;
  int unsigned g_lw;
  int unsigned g_sw;
  int unsigned g_ow;
  bit          tok_bits[$];

  lzss_in_if  in_ch();
  lzss_out_if out_ch();

  lzss_bitstream_decoder #(
    .HISTORY_DEPTH   (HIST_DEPTH),
    .LEN_FIELD_MAX   (LEN_MAX),
    .OFFSET_FIELD_MAX(OFF_MAX)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  lzss_stream_checker #(
    .HISTORY_DEPTH   (HIST_DEPTH),
    .LEN_FIELD_MAX   (LEN_MAX),
    .OFFSET_FIELD_MAX(OFF_MAX)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .errors     (chk_errors),
    .pending    (chk_pending),
    .checked    (chk_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, chk_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver either stalls at random or, on request, holds off for a long stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic first);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= data;
    in_ch.first   <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_OUTPUT_LENGTH;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_len = value;
    cfg_writes++;
  endtask

  task automatic send_header(input int unsigned lw, input int unsigned sw, input int unsigned ow);
    g_lw = lw;
    g_sw = sw;
    g_ow = ow;
    send_byte(8'(lw), 1'b1);
    send_byte(8'(sw), 1'b0);
    send_byte(8'(ow), 1'b0);
    streams++;
  endtask

  function automatic void put_bits(input int unsigned value, input int unsigned w);
    for (int i = int'(w) - 1; i >= 0; i--) tok_bits.push_back(value[i]);
  endfunction

  function automatic void put_literal(input int unsigned value);
    put_bits(3, 2);
    put_bits(value, 8);
  endfunction

  function automatic void put_short(input int unsigned dist_field, input int unsigned len_field);
    put_bits(0, 1);
    put_bits(dist_field, g_sw);
    put_bits(len_field, g_lw);
  endfunction

  function automatic void put_long(input int unsigned dist_field, input int unsigned len_field);
    put_bits(2, 2);
    put_bits(dist_field, g_ow);
    put_bits(len_field, g_lw);
  endfunction

  // Padding with ones can only start a literal, which never completes within one byte.
  task automatic send_tokens(input int unsigned max_bytes);
    logic [7:0]  data;
    int unsigned n;
    while (tok_bits.size() % 8 != 0) tok_bits.push_back(1'b1);
    n = 0;
    while (tok_bits.size() != 0 && n < max_bytes) begin
      for (int k = 0; k < 8; k++) data[7-k] = tok_bits.pop_front();
      send_byte(data, 1'b0);
      n++;
    end
    tok_bits.delete();
  endtask

  task automatic random_stream();
    int unsigned made;
    int unsigned ntok;
    int unsigned cnt;
    int unsigned lf;
    int unsigned df;
    int unsigned room;
    int unsigned cut;
    send_header($urandom_range(0, LEN_MAX),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, OFF_MAX) : $urandom_range(0, 3),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, OFF_MAX) : $urandom_range(0, 3));
    made = 0;
    ntok = $urandom_range(4, 30);
    for (int t = 0; t < ntok && made < cur_len; t++) begin
      lf  = $urandom_range(0, (1 << g_lw) - 1);
      cnt = lf + 2;
      if ($urandom_range(0, 2) == 0 || (cnt > cur_len - made && $urandom_range(0, 3) != 0)) begin
        put_literal($urandom_range(0, 255));
        made++;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          room = (made >= 2) ? made - 2 : 0;
          df   = $urandom_range(0, (1 << g_sw) - 1);
          if (room < df && $urandom_range(0, 3) != 0) df = $urandom_range(0, room);
          put_short(df, lf);
        end else begin
          put_long($urandom_range(0, (1 << g_ow) - 1), lf);
        end
        made += cnt;
      end
    end
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 32'h4000_0000;
    send_tokens(cut);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.first   <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: idle decoder, bad headers, empty stream, extremes, lowered length, end marker.
    send_byte(8'hFF, 1'b0);
    send_byte(8'(LEN_MAX + 1), 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h04, 1'b1);
    send_byte(8'(OFF_MAX + 1), 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    drain();
    write_len(0);
    send_header(2, 3, 4);
    drain();
    write_len(65535);
    send_header(LEN_MAX, OFF_MAX, OFF_MAX);
    put_literal('h00);
    put_literal('hFF);
    put_long((1 << OFF_MAX) - 1, (1 << LEN_MAX) - 1);
    put_short(0, 1);
    put_short((1 << OFF_MAX) - 1, 0);
    send_tokens(32'h4000_0000);
    drain();
    write_len(4);
    send_byte(8'hC3, 1'b0);
    drain();
    write_len(3);
    send_header(1, 0, 0);
    put_literal('h5A);
    put_short(0, 1);
    send_tokens(32'h4000_0000);

    base = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 82 : 0;
      rx_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 17 : 0;
      if (ph == 2) begin
        drain();
        write_len(200);
        holds_asked++;
        random_stream();
      end
      while (items_sent < base + (ph + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end else begin
          if ($urandom_range(0, 2) == 0) begin
            drain();
            case ($urandom_range(0, 19))
              0: write_len(0);
              1: write_len(65535);
              2: write_len($urandom_range(0, 65535));
              default: write_len($urandom_range(1, 60));
            endcase
          end
          random_stream();
        end
      end
    end

    drain();
    $display("Sent %0d compressed bytes in %0d streams with %0d length writes, under three",
             items_sent, streams, cfg_writes);
    $display("idle patterns and one long receiver hold; %0d decoded results compared.",
             chk_results);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
